/* rtl/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the shape collision tester.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int CoordBitsDef = 16;

  typedef enum logic [2:0] {
    FUNC_RECT_RECT   = 3'd0,
    FUNC_CIRC_CIRC   = 3'd1,
    FUNC_POINT_RECT  = 3'd2,
    FUNC_POINT_CIRC  = 3'd3,
    FUNC_CIRC_RECT   = 3'd4
  } func_e;

  // Comparison-only results of the first stage.
  typedef struct packed {
    logic rect_rect;  // both axes overlap strictly
    logic pt_rect;    // point A strictly inside rect B
    logic ext_in;     // one of circle A's axis extremes inside rect B
  } sct_flags_t;

endpackage

/* rtl/shape_collision_tester_top.sv */
// ----------------------------------------------------------------------------
// shape_collision_tester_top
// One 2D collision query per transaction, answered by a one-bit hit.
//
//   channel  ports                          handshake
//   query    func_i, a_*_i, b_*_i           start_i && !busy_o
//   result   hit_o                          valid_o, one cycle, no stall
//
// Three-stage pipeline: compares and differences, squares, sums and select.
// An accepted query is registered in stages 1, 2 and 3 before its result shows.
// One query per cycle; busy_o stays low since the output never stalls.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module shape_collision_tester_top #(
  parameter int COORD_BITS = sct_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [2:0]                   func_i,
  input  logic signed [COORD_BITS-1:0] a_x0_i,
  input  logic signed [COORD_BITS-1:0] a_y0_i,
  input  logic signed [COORD_BITS-1:0] a_x1_i,
  input  logic signed [COORD_BITS-1:0] a_y1_i,
  input  logic [COORD_BITS-2:0]        a_rad_i,
  input  logic signed [COORD_BITS-1:0] b_x0_i,
  input  logic signed [COORD_BITS-1:0] b_y0_i,
  input  logic signed [COORD_BITS-1:0] b_x1_i,
  input  logic signed [COORD_BITS-1:0] b_y1_i,
  input  logic [COORD_BITS-2:0]        b_rad_i,
  output logic                         valid_o,
  output logic                         hit_o
);

  localparam int W = COORD_BITS;

  sct_pkg::sct_flags_t flags_d, s1_flags_q, s2_flags_q;
  logic [W-1:0]        dx0_d, dx1_d, dy0_d, dy1_d, rad_d;
  logic [W-1:0]        s1_dx0_q, s1_dx1_q, s1_dy0_q, s1_dy1_q, s1_rad_q;
  logic [2:0]          s1_func_q, s2_func_q;
  logic [2*W-1:0]      s2_sx0_q, s2_sx1_q, s2_sy0_q, s2_sy1_q, s2_rr_q;
  logic                s1_valid_q, s2_valid_q, s3_valid_q;
  logic                hit_d, hit_q;
  logic [2*W:0]        d00, d01, d10, d11, rr_e;
  logic                b00, b01, b10, b11;
  logic                accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  sct_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .func_i  (func_i),
    .a_x0_i  (a_x0_i),
    .a_y0_i  (a_y0_i),
    .a_x1_i  (a_x1_i),
    .a_y1_i  (a_y1_i),
    .a_rad_i (a_rad_i),
    .b_x0_i  (b_x0_i),
    .b_y0_i  (b_y0_i),
    .b_x1_i  (b_x1_i),
    .b_y1_i  (b_y1_i),
    .b_rad_i (b_rad_i),
    .flags_o (flags_d),
    .dx0_o   (dx0_d),
    .dx1_o   (dx1_d),
    .dy0_o   (dy0_d),
    .dy1_o   (dy1_d),
    .rad_o   (rad_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q  <= func_i;
      s1_flags_q <= flags_d;
      s1_dx0_q   <= dx0_d;
      s1_dx1_q   <= dx1_d;
      s1_dy0_q   <= dy0_d;
      s1_dy1_q   <= dy1_d;
      s1_rad_q   <= rad_d;
    end
  end

  // stage 2: squares
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_func_q  <= s1_func_q;
      s2_flags_q <= s1_flags_q;
      s2_sx0_q   <= (2*W)'(s1_dx0_q) * (2*W)'(s1_dx0_q);
      s2_sx1_q   <= (2*W)'(s1_dx1_q) * (2*W)'(s1_dx1_q);
      s2_sy0_q   <= (2*W)'(s1_dy0_q) * (2*W)'(s1_dy0_q);
      s2_sy1_q   <= (2*W)'(s1_dy1_q) * (2*W)'(s1_dy1_q);
      s2_rr_q    <= (2*W)'(s1_rad_q) * (2*W)'(s1_rad_q);
    end
  end

  // stage 3: distance compares and test select
  assign d00  = {1'b0, s2_sx0_q} + {1'b0, s2_sy0_q};
  assign d01  = {1'b0, s2_sx0_q} + {1'b0, s2_sy1_q};
  assign d10  = {1'b0, s2_sx1_q} + {1'b0, s2_sy0_q};
  assign d11  = {1'b0, s2_sx1_q} + {1'b0, s2_sy1_q};
  assign rr_e = {1'b0, s2_rr_q};
  assign b00  = d00 < rr_e;
  assign b01  = d01 < rr_e;
  assign b10  = d10 < rr_e;
  assign b11  = d11 < rr_e;

  always_comb begin
    case (s2_func_q)
      sct_pkg::FUNC_RECT_RECT:  hit_d = s2_flags_q.rect_rect;
      sct_pkg::FUNC_CIRC_CIRC:  hit_d = b00;
      sct_pkg::FUNC_POINT_RECT: hit_d = s2_flags_q.pt_rect;
      sct_pkg::FUNC_POINT_CIRC: hit_d = b00;
      sct_pkg::FUNC_CIRC_RECT:  hit_d = s2_flags_q.ext_in || b00 || b01 || b10 || b11;
      default:                  hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = s3_valid_q;
  assign hit_o   = s3_valid_q && hit_q;

endmodule

/* rtl/sct_geom.sv */
// ----------------------------------------------------------------------------
// sct_geom
// First-stage geometry: strict rectangle compares, circle extremes, absolute
// coordinate differences and the selected radius.
// ----------------------------------------------------------------------------
module sct_geom #(
  parameter int COORD_BITS = sct_pkg::CoordBitsDef
) (
  input  logic [2:0]                   func_i,
  input  logic signed [COORD_BITS-1:0] a_x0_i,
  input  logic signed [COORD_BITS-1:0] a_y0_i,
  input  logic signed [COORD_BITS-1:0] a_x1_i,
  input  logic signed [COORD_BITS-1:0] a_y1_i,
  input  logic [COORD_BITS-2:0]        a_rad_i,
  input  logic signed [COORD_BITS-1:0] b_x0_i,
  input  logic signed [COORD_BITS-1:0] b_y0_i,
  input  logic signed [COORD_BITS-1:0] b_x1_i,
  input  logic signed [COORD_BITS-1:0] b_y1_i,
  input  logic [COORD_BITS-2:0]        b_rad_i,
  output sct_pkg::sct_flags_t          flags_o,
  output logic [COORD_BITS-1:0]        dx0_o,
  output logic [COORD_BITS-1:0]        dx1_o,
  output logic [COORD_BITS-1:0]        dy0_o,
  output logic [COORD_BITS-1:0]        dy1_o,
  output logic [COORD_BITS-1:0]        rad_o
);

  localparam int W = COORD_BITS;

  function automatic logic [W-1:0] abs_diff(input logic signed [W-1:0] a,
                                            input logic signed [W-1:0] b);
    logic signed [W:0] d;
    d = $signed({a[W-1], a}) - $signed({b[W-1], b});
    if (d < 0) begin
      d = -d;
    end
    return d[W-1:0];
  endfunction

  logic signed [W:0] ax_e, ay_e, bx0_e, by0_e, bx1_e, by1_e, rad_e;
  logic signed [W:0] ext_px, ext_nx, ext_py, ext_ny;
  logic              y_in, x_in;

  assign ax_e  = $signed({a_x0_i[W-1], a_x0_i});
  assign ay_e  = $signed({a_y0_i[W-1], a_y0_i});
  assign bx0_e = $signed({b_x0_i[W-1], b_x0_i});
  assign by0_e = $signed({b_y0_i[W-1], b_y0_i});
  assign bx1_e = $signed({b_x1_i[W-1], b_x1_i});
  assign by1_e = $signed({b_y1_i[W-1], b_y1_i});
  assign rad_e = $signed({2'b00, a_rad_i});

  assign ext_px = ax_e + rad_e;
  assign ext_nx = ax_e - rad_e;
  assign ext_py = ay_e + rad_e;
  assign ext_ny = ay_e - rad_e;

  assign x_in = (a_x0_i > b_x0_i) && (a_x0_i < b_x1_i);
  assign y_in = (a_y0_i > b_y0_i) && (a_y0_i < b_y1_i);

  always_comb begin
    flags_o.rect_rect = (a_x0_i < b_x1_i) && (a_x1_i > b_x0_i) &&
                        (a_y0_i < b_y1_i) && (a_y1_i > b_y0_i);
    flags_o.pt_rect   = x_in && y_in;
    flags_o.ext_in    = (y_in && (ext_px > bx0_e) && (ext_px < bx1_e)) ||
                        (y_in && (ext_nx > bx0_e) && (ext_nx < bx1_e)) ||
                        (x_in && (ext_py > by0_e) && (ext_py < by1_e)) ||
                        (x_in && (ext_ny > by0_e) && (ext_ny < by1_e));
  end

  assign dx0_o = abs_diff(a_x0_i, b_x0_i);
  assign dx1_o = abs_diff(a_x0_i, b_x1_i);
  assign dy0_o = abs_diff(a_y0_i, b_y0_i);
  assign dy1_o = abs_diff(a_y0_i, b_y1_i);

  always_comb begin
    case (func_i)
      sct_pkg::FUNC_CIRC_CIRC:  rad_o = {1'b0, a_rad_i} + {1'b0, b_rad_i};
      sct_pkg::FUNC_POINT_CIRC: rad_o = {1'b0, b_rad_i};
      sct_pkg::FUNC_CIRC_RECT:  rad_o = {1'b0, a_rad_i};
      default:                  rad_o = '0;
    endcase
  end

endmodule

/* rtl/sct_checker.sv */
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks of the collision tester: fixed latency, quiet output.
// ----------------------------------------------------------------------------
module sct_checker #(
  parameter int COORD_BITS = sct_pkg::CoordBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic [2:0]            func_i,
  input logic [COORD_BITS-2:0] b_rad_i,
  input logic                  valid_o,
  input logic                  hit_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 valid_o)
    else $error("result missing three cycles after a transaction");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##3 !valid_o)
    else $error("result without a transaction");

  a_hit_qualified: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !hit_o)
    else $error("hit without strobe");

  a_unused_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i > sct_pkg::FUNC_CIRC_RECT)) |-> ##3 !hit_o)
    else $error("hit on unused selector");

  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i == sct_pkg::FUNC_POINT_CIRC) && (b_rad_i == '0))
    |-> ##3 !hit_o)
    else $error("hit on zero radius circle");

endmodule

bind shape_collision_tester_top sct_checker #(.COORD_BITS(COORD_BITS)) u_sct_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .func_i  (func_i),
  .b_rad_i (b_rad_i),
  .valid_o (valid_o),
  .hit_o   (hit_o)
);

/* sim/shape_collision_checker.sv */
// ----------------------------------------------------------------------------
// shape_collision_checker
// Watches the query and result channels of the shape collision tester,
// predicts the hit bit of every accepted query and compares it, in order,
// with each result strobed on valid_o.
// ----------------------------------------------------------------------------
module shape_collision_checker #(
  parameter int COORD_BITS = sct_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_o,
  input  logic [2:0]                   func_i,
  input  logic signed [COORD_BITS-1:0] a_x0_i,
  input  logic signed [COORD_BITS-1:0] a_y0_i,
  input  logic signed [COORD_BITS-1:0] a_x1_i,
  input  logic signed [COORD_BITS-1:0] a_y1_i,
  input  logic [COORD_BITS-2:0]        a_rad_i,
  input  logic signed [COORD_BITS-1:0] b_x0_i,
  input  logic signed [COORD_BITS-1:0] b_y0_i,
  input  logic signed [COORD_BITS-1:0] b_x1_i,
  input  logic signed [COORD_BITS-1:0] b_y1_i,
  input  logic [COORD_BITS-2:0]        b_rad_i,
  input  logic                         valid_o,
  input  logic                         hit_o,
  input  logic                         flush_i,
  output int unsigned                  pending_o,
  output int unsigned                  err_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  typedef struct {
    logic       hit;
    logic [2:0] fn;
    int         idx;
  } hit_exp_t;

  hit_exp_t    hit_q[$];
  int unsigned mismatches = 0;
  int          query_idx  = 0;
  bit          flushed    = 1'b0;

  assign err_cnt_o = mismatches;
  assign pending_o = hit_q.size();

  function automatic logic open_inside(longint px, longint py, longint x0, longint y0,
                                       longint x1, longint y1);
    return px > x0 && px < x1 && py > y0 && py < y1;
  endfunction

  // squared distance strictly below r squared
  function automatic logic near_enough(longint px, longint py, longint cx, longint cy,
                                       longint r);
    return (px - cx) * (px - cx) + (py - cy) * (py - cy) < r * r;
  endfunction

  function automatic logic collide(logic [2:0] fn, longint ax0, longint ay0, longint ax1,
                                   longint ay1, longint ar, longint bx0, longint by0,
                                   longint bx1, longint by1, longint br);
    case (func_e'(fn))
      FUNC_RECT_RECT:  return ax0 < bx1 && ax1 > bx0 && ay0 < by1 && ay1 > by0;
      FUNC_CIRC_CIRC:  return near_enough(ax0, ay0, bx0, by0, ar + br);
      FUNC_POINT_RECT: return open_inside(ax0, ay0, bx0, by0, bx1, by1);
      FUNC_POINT_CIRC: return near_enough(ax0, ay0, bx0, by0, br);
      FUNC_CIRC_RECT: begin
        return open_inside(ax0 + ar, ay0, bx0, by0, bx1, by1)
            || open_inside(ax0 - ar, ay0, bx0, by0, bx1, by1)
            || open_inside(ax0, ay0 + ar, bx0, by0, bx1, by1)
            || open_inside(ax0, ay0 - ar, bx0, by0, bx1, by1)
            || near_enough(bx0, by0, ax0, ay0, ar)
            || near_enough(bx0, by1, ax0, ay0, ar)
            || near_enough(bx1, by0, ax0, ay0, ar)
            || near_enough(bx1, by1, ax0, ay0, ar);
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void flag(string msg);
    if (mismatches < 10) begin
      $display("[%0t] %s", $time, msg);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i) begin
    hit_exp_t e;
    if (rst_ni) begin
      if (valid_o) begin
        if (hit_q.size() == 0) begin
          flag($sformatf("unexpected result transaction, hit %0b", hit_o));
        end else begin
          e = hit_q.pop_front();
          if (hit_o !== e.hit) begin
            flag($sformatf("query #%0d func %0d: expected hit %0b, got %0b",
                           e.idx, e.fn, e.hit, hit_o));
          end
        end
      end
      if (start_i && !busy_o) begin
        e.fn  = func_i;
        e.idx = query_idx;
        e.hit = collide(func_i, a_x0_i, a_y0_i, a_x1_i, a_y1_i, a_rad_i,
                        b_x0_i, b_y0_i, b_x1_i, b_y1_i, b_rad_i);
        hit_q.push_back(e);
        query_idx++;
      end
      if (flush_i && !flushed) begin
        flushed = 1'b1;
        while (hit_q.size() > 0) begin
          e = hit_q.pop_front();
          flag($sformatf("query #%0d func %0d: result never arrived", e.idx, e.fn));
        end
      end
    end
  end

endmodule

/* sim/shape_collision_tester_top_test.sv */
// ----------------------------------------------------------------------------
// shape_collision_tester_top_test
// Drives collision queries into the shape collision tester: a directed set
// covering every test, boundaries, extremes and unused selectors, then
// clustered and full-range random queries sent in bursts with random gaps.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module shape_collision_tester_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  localparam int CB          = CoordBitsDef;
  localparam int NUM_RANDOM  = 400;
  localparam int STALL_LIMIT = 1000;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [CB-2:0]        rad_t;

  typedef struct {
    logic [2:0] fn;
    coord_t     ax0, ay0, ax1, ay1;
    rad_t       arad;
    coord_t     bx0, by0, bx1, by1;
    rad_t       brad;
  } query_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  func_i;
  coord_t      a_x0_i, a_y0_i, a_x1_i, a_y1_i;
  rad_t        a_rad_i;
  coord_t      b_x0_i, b_y0_i, b_x1_i, b_y1_i;
  rad_t        b_rad_i;
  logic        valid_o;
  logic        hit_o;
  logic        flush;
  int unsigned pending;
  int unsigned err_cnt;
  int          burst_left = 0;
  int          stall_cyc  = 0;

  shape_collision_tester_top #(.COORD_BITS(CB)) i_dut (.*);

  shape_collision_checker #(.COORD_BITS(CB)) i_checker (
    .flush_i  (flush),
    .pending_o(pending),
    .err_cnt_o(err_cnt),
    .*
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        stall_cyc = 0;
      end else begin
        stall_cyc++;
      end
      if (stall_cyc >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic query_t mk(logic [2:0] fn, int ax0, int ay0, int ax1, int ay1,
                                int arad, int bx0, int by0, int bx1, int by1, int brad);
    query_t q;
    q.fn   = fn;
    q.ax0  = coord_t'(ax0);
    q.ay0  = coord_t'(ay0);
    q.ax1  = coord_t'(ax1);
    q.ay1  = coord_t'(ay1);
    q.arad = rad_t'(arad);
    q.bx0  = coord_t'(bx0);
    q.by0  = coord_t'(by0);
    q.bx1  = coord_t'(bx1);
    q.by1  = coord_t'(by1);
    q.brad = rad_t'(brad);
    return q;
  endfunction

  function automatic coord_t jitter(coord_t c, int span, bit wide);
    if (wide) begin
      return coord_t'($urandom);
    end
    return coord_t'(c + $urandom_range(0, 2 * span) - span);
  endfunction

  // mostly well-formed extents, sometimes arbitrary (reversed or wrapped)
  function automatic coord_t far_edge(coord_t c, int span);
    if ($urandom_range(0, 7) == 0) begin
      return coord_t'($urandom);
    end
    return coord_t'(c + $urandom_range(0, 2 * span));
  endfunction

  function automatic rad_t rad_pick(int span);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return rad_t'($urandom);
      default: return rad_t'($urandom_range(0, span));
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    coord_t cx, cy;
    int     span;
    bit     wide;
    wide = ($urandom_range(0, 4) == 0);
    span = $urandom_range(4, 400);
    cx   = coord_t'($urandom);
    cy   = coord_t'($urandom);
    if ($urandom_range(0, 15) == 0) begin
      q.fn = 3'($urandom_range(5, 7));
    end else begin
      q.fn = 3'($urandom_range(0, 4));
    end
    q.ax0  = jitter(cx, span, wide);
    q.ay0  = jitter(cy, span, wide);
    q.bx0  = jitter(cx, span, wide);
    q.by0  = jitter(cy, span, wide);
    q.ax1  = far_edge(q.ax0, span);
    q.ay1  = far_edge(q.ay0, span);
    q.bx1  = far_edge(q.bx0, span);
    q.by1  = far_edge(q.by0, span);
    q.arad = rad_pick(span);
    q.brad = rad_pick(span);
    return q;
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_query(input query_t q);
    start_i <= 1'b1;
    func_i  <= q.fn;
    a_x0_i  <= q.ax0;
    a_y0_i  <= q.ay0;
    a_x1_i  <= q.ax1;
    a_y1_i  <= q.ay1;
    a_rad_i <= q.arad;
    b_x0_i  <= q.bx0;
    b_y0_i  <= q.by0;
    b_x1_i  <= q.bx1;
    b_y1_i  <= q.by1;
    b_rad_i <= q.brad;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic wait_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    query_t directed[$];
    rst_ni  = 1'b0;
    start_i = 1'b0;
    flush   = 1'b0;
    func_i  = '0;
    a_x0_i  = '0;
    a_y0_i  = '0;
    a_x1_i  = '0;
    a_y1_i  = '0;
    a_rad_i = '0;
    b_x0_i  = '0;
    b_y0_i  = '0;
    b_x1_i  = '0;
    b_y1_i  = '0;
    b_rad_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed.push_back(mk(FUNC_RECT_RECT, 0, 0, 10, 10, 0, 5, 5, 15, 15, 0));
    directed.push_back(mk(FUNC_RECT_RECT, 0, 0, 10, 10, 0, 10, 0, 20, 10, 0));
    directed.push_back(mk(FUNC_RECT_RECT, -32768, -32768, 32767, 32767, 32767,
                          -32768, -32768, 32767, 32767, 32767));
    directed.push_back(mk(FUNC_RECT_RECT, 10, 10, 0, 0, 0, 0, 0, 10, 10, 0));
    directed.push_back(mk(FUNC_CIRC_CIRC, 0, 0, 0, 0, 2, 3, 4, 0, 0, 3));
    directed.push_back(mk(FUNC_CIRC_CIRC, 0, 0, 0, 0, 3, 3, 4, 0, 0, 3));
    directed.push_back(mk(FUNC_CIRC_CIRC, -1, -1, -1, -1, 0, -1, -1, -1, -1, 0));
    directed.push_back(mk(FUNC_CIRC_CIRC, -32768, -32768, 0, 0, 32767,
                          32767, 32767, 0, 0, 32767));
    directed.push_back(mk(FUNC_CIRC_CIRC, -32767, 0, 0, 0, 32767, 32767, 0, 0, 0, 32767));
    directed.push_back(mk(FUNC_CIRC_CIRC, -32766, 0, 0, 0, 32767, 32767, 0, 0, 0, 32767));
    directed.push_back(mk(FUNC_POINT_RECT, 5, 5, 0, 0, 0, 0, 0, 10, 10, 0));
    directed.push_back(mk(FUNC_POINT_RECT, 0, 5, 0, 0, 0, 0, 0, 10, 10, 0));
    directed.push_back(mk(FUNC_POINT_RECT, 32767, -32768, 0, 0, 0,
                          -32768, -32768, 32767, 32767, 0));
    directed.push_back(mk(FUNC_POINT_CIRC, 0, 0, 0, 0, 0, 3, 4, 0, 0, 5));
    directed.push_back(mk(FUNC_POINT_CIRC, 0, 0, 0, 0, 0, 3, 4, 0, 0, 6));
    directed.push_back(mk(FUNC_POINT_CIRC, -32768, -32768, -1, -1, 32767,
                          32767, 32767, -1, -1, 32767));
    directed.push_back(mk(FUNC_CIRC_RECT, 0, 0, 0, 0, 10, 5, -2, 20, 2, 0));
    directed.push_back(mk(FUNC_CIRC_RECT, 0, 0, 0, 0, 10, 6, 6, 30, 30, 0));
    directed.push_back(mk(FUNC_CIRC_RECT, 0, 0, 0, 0, 5, 4, 4, 30, 30, 0));
    directed.push_back(mk(FUNC_CIRC_RECT, 5, 5, 0, 0, 0, 0, 0, 10, 10, 0));
    directed.push_back(mk(FUNC_CIRC_RECT, 32767, 32767, 0, 0, 32767,
                          -32768, -32768, 32767, 32767, 0));
    directed.push_back(mk(3'd5, 0, 0, 10, 10, 32767, 5, 5, 15, 15, 32767));
    directed.push_back(mk(3'd6, -1, -1, -1, -1, 32767, -1, -1, -1, -1, 32767));
    directed.push_back(mk(3'd7, 0, 0, 0, 0, 32767, 0, 0, 0, 0, 32767));

    foreach (directed[i]) begin
      send_query(directed[i]);
    end
    wait_results();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_query(rand_query());
      if (i == NUM_RANDOM / 2) begin
        wait_results();
      end
    end
    wait_results();
    repeat (8) @(negedge clk_i);
    flush <= 1'b1;
    repeat (2) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sct_pkg.sv
rtl/sct_geom.sv
rtl/shape_collision_tester_top.sv
rtl/sct_checker.sv
sim/shape_collision_checker.sv
sim/shape_collision_tester_top_test.sv
